FILE: rtl/gpdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph point delta decoder package
// Shared payload types, control and status bundles, flag bit positions and
// the helpers that interpret one stored point flag.
// ----------------------------------------------------------------------------
package gpdd_pkg;

    localparam int MAX_POINTS_DEFAULT = 1024;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 11;
    localparam int VALUE_W = 16;
    localparam int FIRST_W = 10;
    localparam int FLAG_W  = 5;

    localparam int FLAG_X_SHORT = 1;
    localparam int FLAG_Y_SHORT = 2;
    localparam int REPEAT       = 3;
    localparam int FLAG_X_SAME  = 4;
    localparam int FLAG_Y_SAME  = 5;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic               start_req;
        logic [COUNT_W-1:0] point_count;
    } gpdd_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] coord_value;
        logic                      axis;
        logic [FIRST_W-1:0]        first_point;
        logic [COUNT_W-1:0]        span;
        logic                      last;
    } gpdd_coord_t;

    typedef struct packed {
        logic load_item;
        logic flag_write;
        logic rep_load;
        logic rep_write;
        logic begin_axis;
        logic axis_sel;
        logic high_load;
        logic finish;
        logic use_word;
        logic scan_rd;
        logic scan_step;
        logic flag_capture;
        logic emit;
        logic commit;
    } gpdd_cmd_t;

    typedef struct packed {
        logic start_req;
        logic repeat_bit;
        logic fill_last;
        logic fill_done;
        logic rep_zero;
        logic scan_end;
        logic scan_skip;
        logic cur_short;
        logic run_empty;
        logic axis;
        logic out_free;
    } gpdd_stat_t;

    function automatic logic [FLAG_W-1:0] flag_of(input logic [BYTE_W-1:0] raw);
        return raw[FLAG_W:1];
    endfunction

    function automatic logic is_short(input logic axis, input logic [FLAG_W-1:0] flag);
        return axis ? flag[FLAG_Y_SHORT-1] : flag[FLAG_X_SHORT-1];
    endfunction

    function automatic logic is_sign(input logic axis, input logic [FLAG_W-1:0] flag);
        return axis ? flag[FLAG_Y_SAME-1] : flag[FLAG_X_SAME-1];
    endfunction

    function automatic logic is_skip(input logic axis, input logic [FLAG_W-1:0] flag);
        return !is_short(axis, flag) && is_sign(axis, flag);
    endfunction

endpackage

FILE: rtl/gpdd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph point delta decoder controller
// Sequences flag expansion, repeat fill, skip-run scans and result emission,
// and drives the datapath through one command bundle.
// ----------------------------------------------------------------------------
module gpdd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  gpdd_pkg::gpdd_stat_t  stat,
    output gpdd_pkg::gpdd_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_WAIT,
        S_DECODE,
        S_REPFILL,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FLAG,
        PH_REPEAT,
        PH_X_BYTE,
        PH_X_LOW,
        PH_Y_BYTE,
        PH_Y_LOW
    } phase_t;

    state_t state_reg;
    state_t state_next;
    phase_t phase_reg;
    phase_t phase_next;
    logic   fin_mode_reg;
    logic   fin_mode_next;
    logic   need_emit;

    assign item_stall = (state_reg != S_WAIT);
    assign need_emit  = fin_mode_reg || !stat.run_empty;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        phase_next    = phase_reg;
        fin_mode_next = fin_mode_reg;
        case (state_reg)
            S_WAIT:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                    if (stat.start_req)
                    begin
                        phase_next = PH_FLAG;
                    end
                end
            end
            S_DECODE:
            begin
                state_next = S_WAIT;
                case (phase_reg)
                    PH_FLAG:
                    begin
                        cmd.flag_write = 1'b1;
                        if (stat.repeat_bit)
                        begin
                            phase_next = PH_REPEAT;
                        end
                        else if (stat.fill_last)
                        begin
                            cmd.begin_axis = 1'b1;
                            cmd.axis_sel   = 1'b0;
                            fin_mode_next  = 1'b0;
                            state_next     = S_SCAN_RD;
                        end
                    end
                    PH_REPEAT:
                    begin
                        cmd.rep_load = 1'b1;
                        state_next   = S_REPFILL;
                    end
                    PH_X_BYTE, PH_Y_BYTE:
                    begin
                        if (stat.cur_short)
                        begin
                            cmd.finish    = 1'b1;
                            fin_mode_next = 1'b1;
                            state_next    = S_SCAN_RD;
                        end
                        else
                        begin
                            cmd.high_load = 1'b1;
                            phase_next    = (phase_reg == PH_Y_BYTE) ? PH_Y_LOW : PH_X_LOW;
                        end
                    end
                    PH_X_LOW, PH_Y_LOW:
                    begin
                        cmd.finish    = 1'b1;
                        cmd.use_word  = 1'b1;
                        fin_mode_next = 1'b1;
                        state_next    = S_SCAN_RD;
                    end
                    default:
                    begin
                        state_next = S_WAIT;
                    end
                endcase
            end
            S_REPFILL:
            begin
                if (!stat.rep_zero)
                begin
                    cmd.rep_write = 1'b1;
                end
                else if (stat.fill_done)
                begin
                    cmd.begin_axis = 1'b1;
                    cmd.axis_sel   = 1'b0;
                    fin_mode_next  = 1'b0;
                    state_next     = S_SCAN_RD;
                end
                else
                begin
                    phase_next = PH_FLAG;
                    state_next = S_WAIT;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (stat.scan_skip)
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SCAN_RD;
                end
                else
                begin
                    cmd.flag_capture = 1'b1;
                    state_next       = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!need_emit || stat.out_free)
                begin
                    cmd.emit   = need_emit;
                    cmd.commit = 1'b1;
                    if (stat.scan_end && !stat.axis)
                    begin
                        cmd.begin_axis = 1'b1;
                        cmd.axis_sel   = 1'b1;
                        fin_mode_next  = 1'b0;
                        state_next     = S_SCAN_RD;
                    end
                    else if (stat.scan_end)
                    begin
                        phase_next = PH_IDLE;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        phase_next = stat.axis ? PH_Y_BYTE : PH_X_BYTE;
                        state_next = S_WAIT;
                    end
                end
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_WAIT;
            phase_reg    <= PH_IDLE;
            fin_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            fin_mode_reg <= fin_mode_next;
        end
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("Result loaded while the output register is occupied.");

    a_rep_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rep_write |-> !stat.fill_done)
        else $error("Repeat fill beyond the glyph point count.");

    a_scan_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_CHK) |-> $past(cmd.scan_rd))
        else $error("Flag check without a preceding flag read.");

endmodule

FILE: rtl/gpdd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph point delta decoder datapath
// Holds the flag memory, the fill and scan pointers, the coordinate
// accumulator and the output register.
// ----------------------------------------------------------------------------
module gpdd_datapath #(
    parameter int MAX_POINTS = gpdd_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gpdd_pkg::gpdd_item_t  item,
    input  gpdd_pkg::gpdd_cmd_t   cmd,
    output gpdd_pkg::gpdd_stat_t  stat,
    input  logic                  coord_stall,
    output logic                  coord_valid,
    output gpdd_pkg::gpdd_coord_t coord
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CMP_W  = (CNT_W > gpdd_pkg::COUNT_W) ? CNT_W : gpdd_pkg::COUNT_W;
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int FLAG_W = gpdd_pkg::FLAG_W;
    localparam int BYTE_W = gpdd_pkg::BYTE_W;
    localparam int VAL_W  = gpdd_pkg::VALUE_W;
    localparam logic [CMP_W-1:0] MAX_CNT = CMP_W'(MAX_POINTS);

    logic [FLAG_W-1:0] flag_mem [MAX_POINTS];

    logic [CMP_W-1:0]  total_reg;
    logic [CMP_W-1:0]  fill_reg;
    logic [CMP_W-1:0]  coord_idx_reg;
    logic [CMP_W-1:0]  scan_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] high_reg;
    logic [FLAG_W-1:0] held_reg;
    logic [FLAG_W-1:0] cur_flag_reg;
    logic [FLAG_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0] rep_cnt_reg;
    logic [VAL_W-1:0]  acc_reg;
    logic              axis_reg;
    gpdd_pkg::gpdd_coord_t out_reg;

    logic [CMP_W-1:0]  pc_ext;
    logic [CMP_W-1:0]  total_load;
    logic [CMP_W-1:0]  remain;
    logic [BYTE_W-1:0] rep_load_val;
    logic [FLAG_W-1:0] byte_flag;
    logic              fill_room;
    logic              wr_en;
    logic [FLAG_W-1:0] wr_data;
    logic [VAL_W-1:0]  short_mag;
    logic [VAL_W-1:0]  delta;
    logic [CMP_W-1:0]  span;

    always_comb
    begin
        pc_ext       = CMP_W'(item.point_count);
        total_load   = (pc_ext == '0) ? CMP_W'(1) : ((pc_ext > MAX_CNT) ? MAX_CNT : pc_ext);
        remain       = total_reg - fill_reg;
        rep_load_val = (CMP_W'(byte_reg) > remain) ? remain[BYTE_W-1:0] : byte_reg;
        byte_flag    = gpdd_pkg::flag_of(byte_reg);
        fill_room    = (fill_reg < total_reg);
        wr_en        = (cmd.flag_write && fill_room) || cmd.rep_write;
        wr_data      = cmd.rep_write ? held_reg : byte_flag;
        short_mag    = {{(VAL_W-BYTE_W){1'b0}}, byte_reg};
        if (cmd.use_word)
        begin
            delta = {high_reg, byte_reg};
        end
        else if (gpdd_pkg::is_sign(axis_reg, cur_flag_reg))
        begin
            delta = short_mag;
        end
        else
        begin
            delta = {VAL_W{1'b0}} - short_mag;
        end
        span = scan_reg - coord_idx_reg;
    end

    always_comb
    begin
        stat.start_req  = item.start_req;
        stat.repeat_bit = byte_flag[gpdd_pkg::REPEAT-1];
        stat.fill_last  = (CMP_W'(fill_reg + 1'b1) >= total_reg);
        stat.fill_done  = (fill_reg >= total_reg);
        stat.rep_zero   = (rep_cnt_reg == '0);
        stat.scan_end   = (scan_reg >= total_reg);
        stat.scan_skip  = gpdd_pkg::is_skip(axis_reg, rd_data_reg);
        stat.cur_short  = gpdd_pkg::is_short(axis_reg, cur_flag_reg);
        stat.run_empty  = (scan_reg == coord_idx_reg);
        stat.axis       = axis_reg;
        stat.out_free   = !out_valid_reg || !coord_stall;
    end

    assign coord_valid = out_valid_reg;
    assign coord       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            fill_reg      <= '0;
            coord_idx_reg <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item && item.start_req)
            begin
                total_reg <= total_load;
                fill_reg  <= '0;
            end
            else if (wr_en)
            begin
                fill_reg <= CMP_W'(fill_reg + 1'b1);
            end
            if (cmd.begin_axis || (cmd.load_item && item.start_req))
            begin
                coord_idx_reg <= '0;
                scan_reg      <= '0;
            end
            else if (cmd.finish)
            begin
                scan_reg <= CMP_W'(coord_idx_reg + 1'b1);
            end
            else if (cmd.scan_step)
            begin
                scan_reg <= CMP_W'(scan_reg + 1'b1);
            end
            else if (cmd.commit)
            begin
                coord_idx_reg <= scan_reg;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!coord_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            byte_reg <= item.data_byte;
        end
        if (cmd.flag_write)
        begin
            held_reg <= byte_flag;
        end
        if (cmd.rep_load)
        begin
            rep_cnt_reg <= rep_load_val;
        end
        else if (cmd.rep_write)
        begin
            rep_cnt_reg <= rep_cnt_reg - 1'b1;
        end
        if (cmd.high_load)
        begin
            high_reg <= byte_reg;
        end
        if (cmd.begin_axis)
        begin
            acc_reg  <= '0;
            axis_reg <= cmd.axis_sel;
        end
        else if (cmd.finish)
        begin
            acc_reg <= acc_reg + delta;
        end
        if (cmd.flag_capture)
        begin
            cur_flag_reg <= rd_data_reg;
        end
        if (cmd.emit)
        begin
            out_reg.coord_value <= acc_reg;
            out_reg.axis        <= axis_reg;
            out_reg.first_point <= coord_idx_reg[gpdd_pkg::FIRST_W-1:0];
            out_reg.span        <= span[gpdd_pkg::COUNT_W-1:0];
            out_reg.last        <= stat.scan_end && axis_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            flag_mem[fill_reg[IDX_W-1:0]] <= wr_data;
        end
        if (cmd.scan_rd)
        begin
            rd_data_reg <= flag_mem[scan_reg[IDX_W-1:0]];
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= total_reg)
        else $error("Flag fill pointer ran past the point count.");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= total_reg)
        else $error("Scan pointer ran past the point count.");

endmodule

FILE: rtl/glyph_point_delta_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph point delta decoder
// Expands simple-glyph flag bytes into a flag memory, then decodes the X and
// Y deltas into absolute coordinates with their first point and span.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  item    | item_valid / item_stall   | data_byte, start_req, point_count
//  coord   | coord_valid / coord_stall | coord_value, axis, first_point, span, last
//
// A plain byte is taken in the wait step and then decoded in the decode step.
// A repeat count byte then writes the held flag once for each repeated point.
// A byte that ends the flags or completes a coordinate then reads and checks
// each scanned flag in turn, and finishes in the emit step.
// Reset is immediate; the flag memory is not cleared.
// A stalled result holds the block in its emit step until the beat leaves.
// ----------------------------------------------------------------------------
module glyph_point_delta_decoder_top #(
    parameter int MAX_POINTS = gpdd_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  gpdd_pkg::gpdd_item_t  item,
    output logic                  coord_valid,
    input  logic                  coord_stall,
    output gpdd_pkg::gpdd_coord_t coord
);

    gpdd_pkg::gpdd_cmd_t  cmd;
    gpdd_pkg::gpdd_stat_t stat;

    gpdd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    gpdd_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cmd         (cmd),
        .stat        (stat),
        .coord_stall (coord_stall),
        .coord_valid (coord_valid),
        .coord       (coord)
    );

endmodule
